### rtl/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared widths, codes and state types of the page-frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int FRAME_W     = 24;
  localparam int PTE_W       = 32;
  localparam int ACT_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int PAGES_W     = 13;
  localparam int OFS_W       = 14;
  localparam int REG_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_REGIONS = 3;
  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = 5;
  localparam int PTE_KEEP_W  = 8;

  localparam logic [FRAME_W:0]   FRAME_SPACE = 25'h1000000;
  localparam logic [OFS_W-1:0]   OFS_LIMIT   = 14'd8192;

  typedef enum logic [ACT_W-1:0] {
    ACT_MARK_KERNEL = 3'd0,
    ACT_MARK_BOOT   = 3'd1,
    ACT_QUERY       = 3'd2,
    ACT_ALLOC       = 3'd3,
    ACT_RELOCATE    = 3'd4,
    ACT_INVERT      = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_MARKED = 2'd1,
    ST_FAIL   = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R0_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R0_PAGES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R1_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R1_PAGES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_R2_START     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_R2_PAGES     = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_RD,
    S_CHK,
    S_ALC_RD,
    S_ALC_CHK,
    S_INV_RD,
    S_INV_WR
  } state_t;

endpackage

### rtl/pfba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba interfaces
// Request, result and register-write channels of the allocator.
// ----------------------------------------------------------------------------
interface pfba_in_if;
  logic                           valid;
  logic                           ready;
  logic [pfba_pkg::ACT_W-1:0]     action;
  logic [pfba_pkg::FRAME_W-1:0]   frame;
  logic [pfba_pkg::PTE_W-1:0]     pte_in;
  modport source (output valid, action, frame, pte_in, input ready);
  modport sink   (input valid, action, frame, pte_in, output ready);
endinterface

interface pfba_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfba_pkg::STATUS_W-1:0]  status;
  logic [pfba_pkg::FRAME_W-1:0]   frame_out;
  logic                           kernel_free;
  logic                           boot_free;
  logic [pfba_pkg::PTE_W-1:0]     pte_out;
  modport source (output valid, status, frame_out, kernel_free, boot_free, pte_out,
                  input ready);
  modport sink   (input valid, status, frame_out, kernel_free, boot_free, pte_out,
                  output ready);
endinterface

interface pfba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pfba_pkg::CFG_IDX_W-1:0]   index;
  logic [pfba_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pfba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 384
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/page_frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// Kernel and boot page-usage bitmaps over up to three page-frame regions.
// ----------------------------------------------------------------------------
// Both bitmaps live in 32-bit-word RAMs, one slot per page, region r at slot
// r*REGION_PAGES. After reset the block clears both RAMs one map word per
// cycle (384 words at the default sizes) before it takes its first item;
// register writes are taken throughout. Mark, query and relocate of a
// kernel-free page pass through lookup, RAM read and check/write-back.
// Allocate, and relocate of a kernel-used page, walk the maps from the
// cursor with one RAM read and one check per map word, plus a lookup, read
// and check for each candidate page whose frame also lies in a lower region,
// and another read and check of its word when that page turns out to be
// used. Invert sweeps the active regions with one read and one write per
// boot-map word. Unknown actions answer at once. One item is in work at a
// time; the result waits in an output register until taken.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core #(
  parameter int REGIONS      = 3,
  parameter int REGION_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  pfba_in_if.sink     in_ch,
  pfba_out_if.source  out_ch,
  pfba_cfg_if.sink    cfg_ch
);
  import pfba_pkg::*;

  localparam int NREG  = (REGIONS < CFG_REGIONS) ? REGIONS : CFG_REGIONS;
  localparam int TOTAL = REGIONS * REGION_PAGES;
  localparam int WORDS = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW    = AW + BIT_W;

  // configuration
  logic [REG_W-1:0]   rcount_r;
  logic [FRAME_W-1:0] start_r [CFG_REGIONS];
  logic [PAGES_W-1:0] pages_r [CFG_REGIONS];

  logic [PAGES_W-1:0] eff_c [CFG_REGIONS];
  logic [PAGES_W-1:0] eff_r [CFG_REGIONS];
  logic [REG_W-1:0]   n_c, n_r;
  logic [OFS_W-1:0]   sh_lo_c [CFG_REGIONS][CFG_REGIONS];
  logic [OFS_W-1:0]   sh_hi_c [CFG_REGIONS][CFG_REGIONS];
  logic [OFS_W-1:0]   sh_lo_r [CFG_REGIONS][CFG_REGIONS];
  logic [OFS_W-1:0]   sh_hi_r [CFG_REGIONS][CFG_REGIONS];

  // control
  state_t             state_r, state_nxt;
  logic               out_valid_r;
  logic [AW-1:0]      clr_r;
  logic [REG_W-1:0]   scan_region_r;
  logic [PAGES_W-1:0] scan_offset_r;

  // item and work registers
  logic [ACT_W-1:0]   act_r;
  logic [FRAME_W-1:0] frame_r;
  logic [PTE_W-1:0]   pte_r;
  logic               probe_r;
  logic               hit_r;
  logic [SW-1:0]      slot_r;
  logic               kf_r, bf_r;
  logic [REG_W-1:0]   cur_reg_r;
  logic [OFS_W-1:0]   cur_ofs_r;
  logic [OFS_W-1:0]   cand_ofs_r;
  logic [FRAME_W-1:0] cand_f_r;

  logic [STATUS_W-1:0] o_status_r;
  logic [FRAME_W-1:0]  o_frame_r;
  logic                o_kf_r, o_bf_r;
  logic [PTE_W-1:0]    o_pte_r;

  // RAM ports
  logic                 k_we, b_we;
  logic [AW-1:0]        k_waddr, b_waddr, rd_addr;
  logic [WORD_BITS-1:0] k_wdata, b_wdata, kdata, bdata;

  logic accept;
  logic act_known;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcount_r <= REG_W'(1);
      for (int r = 0; r < CFG_REGIONS; r++) begin
        start_r[r] <= '0;
        pages_r[r] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_REGION_COUNT: rcount_r   <= cfg_ch.data[REG_W-1:0];
        CFG_R0_START:     start_r[0] <= cfg_ch.data[FRAME_W-1:0];
        CFG_R0_PAGES:     pages_r[0] <= cfg_ch.data[PAGES_W-1:0];
        CFG_R1_START:     start_r[1] <= cfg_ch.data[FRAME_W-1:0];
        CFG_R1_PAGES:     pages_r[1] <= cfg_ch.data[PAGES_W-1:0];
        CFG_R2_START:     start_r[2] <= cfg_ch.data[FRAME_W-1:0];
        CFG_R2_PAGES:     pages_r[2] <= cfg_ch.data[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [OFS_W-1:0] clamp_ofs(input logic signed [FRAME_W+1:0] v);
    logic [OFS_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({12'b0, OFS_LIMIT})) begin
      res = OFS_LIMIT;
    end else begin
      res = v[OFS_W-1:0];
    end
    return res;
  endfunction

  // effective sizes, active count and the offset ranges of region i
  // that fall inside lower region r
  always_comb begin
    logic [FRAME_W:0] room;
    logic [FRAME_W:0] p;
    logic signed [FRAME_W+1:0] d, e;
    for (int r = 0; r < CFG_REGIONS; r++) begin
      room = FRAME_SPACE - {1'b0, start_r[r]};
      p    = (FRAME_W+1)'(pages_r[r]);
      if (p > (FRAME_W+1)'(REGION_PAGES)) p = (FRAME_W+1)'(REGION_PAGES);
      if (p > room) p = room;
      eff_c[r] = p[PAGES_W-1:0];
    end
    n_c = (int'(rcount_r) > NREG) ? REG_W'(NREG) : rcount_r;
    for (int i = 0; i < CFG_REGIONS; i++) begin
      for (int r = 0; r < CFG_REGIONS; r++) begin
        d = $signed({2'b00, start_r[r]}) - $signed({2'b00, start_r[i]});
        e = d + $signed({13'b0, eff_c[r]});
        sh_lo_c[i][r] = clamp_ofs(d);
        sh_hi_c[i][r] = clamp_ofs(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_c;
    for (int i = 0; i < CFG_REGIONS; i++) begin
      eff_r[i] <= eff_c[i];
      for (int r = 0; r < CFG_REGIONS; r++) begin
        sh_lo_r[i][r] <= sh_lo_c[i][r];
        sh_hi_r[i][r] <= sh_hi_c[i][r];
      end
    end
  end

  // ---------------------------------------------------------------- maps
  pfba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_kmap (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(rd_addr), .rdata(kdata)
  );

  pfba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_bmap (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(rd_addr), .rdata(bdata)
  );

  // ---------------------------------------------------------------- lookup
  logic [FRAME_W-1:0] loc_f;
  logic               loc_hit;
  logic [SW-1:0]      loc_slot;

  assign loc_f = probe_r ? cand_f_r : frame_r;

  always_comb begin
    logic [FRAME_W-1:0] diff;
    loc_hit  = 1'b0;
    loc_slot = '0;
    for (int r = 0; r < NREG; r++) begin
      diff = loc_f - start_r[r];
      if (!loc_hit && (REG_W'(r) < n_r) && (loc_f >= start_r[r]) &&
          (diff < FRAME_W'(eff_r[r]))) begin
        loc_hit  = 1'b1;
        loc_slot = SW'(r * REGION_PAGES) + SW'(diff);
      end
    end
  end

  logic                 item_kf, item_bf;
  logic [WORD_BITS-1:0] slot_oh;
  logic [AW-1:0]        slot_word;

  assign slot_word = slot_r[SW-1:BIT_W];
  assign slot_oh   = WORD_BITS'(1) << slot_r[BIT_W-1:0];
  assign item_kf   = !hit_r || !kdata[slot_r[BIT_W-1:0]];
  assign item_bf   = !hit_r || !bdata[slot_r[BIT_W-1:0]];

  // ---------------------------------------------------------------- scan word
  logic                 cur_ok;
  logic [FRAME_W-1:0]   cur_start;
  logic [PAGES_W-1:0]   cur_eff;
  logic [SW-1:0]        cur_slot;
  logic [AW-1:0]        cur_word;
  logic [BIT_W-1:0]     b0;
  logic [OFS_W:0]       ofs_k [WORD_BITS];
  logic [WORD_BITS-1:0] vmask, shmask, free_mask, pick_oh;
  logic [BIT_W-1:0]     pick;
  logic                 pick_any, pick_shadow;
  logic [OFS_W-1:0]     pick_ofs, next_ofs;
  logic [FRAME_W-1:0]   pick_frame;
  logic                 alc_end, alc_skip;

  assign cur_ok    = cur_reg_r < REG_W'(CFG_REGIONS);
  assign cur_start = cur_ok ? start_r[cur_reg_r] : '0;
  assign cur_eff   = cur_ok ? eff_r[cur_reg_r] : '0;
  assign cur_slot  = SW'(cur_reg_r) * SW'(REGION_PAGES) + SW'(cur_ofs_r);
  assign cur_word  = cur_slot[SW-1:BIT_W];
  assign b0        = cur_slot[BIT_W-1:0];
  assign next_ofs  = cur_ofs_r + OFS_W'(WORD_BITS) - OFS_W'(b0);
  assign alc_end   = cur_reg_r >= n_r;
  assign alc_skip  = cur_ofs_r >= OFS_W'(cur_eff);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      ofs_k[k]  = (OFS_W+1)'(cur_ofs_r) + (OFS_W+1)'(k) - (OFS_W+1)'(b0);
      vmask[k]  = (BIT_W'(k) >= b0) && (ofs_k[k] < (OFS_W+1)'(cur_eff));
      shmask[k] = 1'b0;
      for (int r = 0; r < CFG_REGIONS; r++) begin
        if (cur_ok && (REG_W'(r) < cur_reg_r) && (REG_W'(r) < n_r) &&
            (ofs_k[k] >= (OFS_W+1)'(sh_lo_r[cur_reg_r][r])) &&
            (ofs_k[k] <  (OFS_W+1)'(sh_hi_r[cur_reg_r][r]))) begin
          shmask[k] = 1'b1;
        end
      end
    end
  end

  assign free_mask = vmask & (shmask | ~(kdata | bdata));
  assign pick_any  = |free_mask;

  always_comb begin
    pick = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (free_mask[k]) pick = BIT_W'(k);
    end
  end

  assign pick_oh     = WORD_BITS'(1) << pick;
  assign pick_shadow = shmask[pick];
  assign pick_ofs    = cur_ofs_r + OFS_W'(pick) - OFS_W'(b0);
  assign pick_frame  = cur_start + FRAME_W'(pick_ofs);

  // ---------------------------------------------------------------- fsm
  assign accept       = in_ch.valid && in_ch.ready;
  assign act_known    = in_ch.action <= ACT_INVERT;
  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action) inside
            ACT_MARK_KERNEL, ACT_MARK_BOOT, ACT_QUERY, ACT_RELOCATE: state_nxt = S_LOOK;
            ACT_ALLOC:  state_nxt = S_ALC_RD;
            ACT_INVERT: state_nxt = S_INV_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: state_nxt = S_RD;
      S_RD:   state_nxt = S_CHK;
      S_CHK: begin
        if (probe_r) begin
          state_nxt = (item_kf && item_bf) ? S_IDLE : S_ALC_RD;
        end else if (act_r == ACT_RELOCATE && !item_kf) begin
          state_nxt = S_ALC_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ALC_RD: begin
        if (alc_end)       state_nxt = S_IDLE;
        else if (alc_skip) state_nxt = S_ALC_RD;
        else               state_nxt = S_ALC_CHK;
      end
      S_ALC_CHK: begin
        if (!pick_any)        state_nxt = S_ALC_RD;
        else if (pick_shadow) state_nxt = S_LOOK;
        else                  state_nxt = S_IDLE;
      end
      S_INV_RD: begin
        if (alc_end)       state_nxt = S_IDLE;
        else if (alc_skip) state_nxt = S_INV_RD;
        else               state_nxt = S_INV_WR;
      end
      S_INV_WR: state_nxt = S_INV_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  logic                fin;
  logic [STATUS_W-1:0] f_status;
  logic [FRAME_W-1:0]  f_frame;
  logic                f_kf, f_bf;
  logic [PTE_W-1:0]    f_pte;
  logic                alc_ok, alc_fail;
  logic [FRAME_W-1:0]  alc_f;
  logic [OFS_W-1:0]    alc_ofs;
  logic                is_reloc;

  assign is_reloc = act_r == ACT_RELOCATE;
  assign rd_addr  = (state_r == S_RD) ? slot_word : cur_word;

  always_comb begin
    fin      = 1'b0;
    f_status = ST_OK;
    f_frame  = '0;
    f_kf     = 1'b0;
    f_bf     = 1'b0;
    f_pte    = '0;
    k_we     = 1'b0;
    b_we     = 1'b0;
    k_waddr  = slot_word;
    b_waddr  = slot_word;
    k_wdata  = kdata | slot_oh;
    b_wdata  = bdata | slot_oh;
    alc_ok   = 1'b0;
    alc_fail = 1'b0;
    alc_f    = cand_f_r;
    alc_ofs  = cand_ofs_r;
    unique case (state_r)
      S_CLEAR: begin
        k_we    = 1'b1;
        b_we    = 1'b1;
        k_waddr = clr_r;
        b_waddr = clr_r;
        k_wdata = '0;
        b_wdata = '0;
      end
      S_IDLE: begin
        if (accept && !act_known) begin
          fin      = 1'b1;
          f_status = ST_FAIL;
        end
      end
      S_CHK: begin
        if (probe_r) begin
          if (item_kf && item_bf) begin
            b_we   = 1'b1;
            alc_ok = 1'b1;
          end
        end else begin
          f_kf = item_kf;
          f_bf = item_bf;
          case (act_r)
            ACT_MARK_KERNEL: begin
              fin = 1'b1;
              if (!hit_r)        f_status = ST_FAIL;
              else if (!item_kf) f_status = ST_MARKED;
              else               k_we = 1'b1;
            end
            ACT_MARK_BOOT: begin
              fin = 1'b1;
              if (!hit_r)        f_status = ST_FAIL;
              else if (!item_bf) f_status = ST_MARKED;
              else               b_we = 1'b1;
            end
            ACT_RELOCATE: begin
              if (item_kf) begin
                fin     = 1'b1;
                f_frame = frame_r;
                f_pte   = pte_r;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_ALC_RD: begin
        if (alc_end) alc_fail = 1'b1;
      end
      S_ALC_CHK: begin
        b_waddr = cur_word;
        b_wdata = bdata | pick_oh;
        if (pick_any && !pick_shadow) begin
          b_we    = 1'b1;
          alc_ok  = 1'b1;
          alc_f   = pick_frame;
          alc_ofs = pick_ofs;
        end
      end
      S_INV_RD: begin
        if (alc_end) fin = 1'b1;
      end
      S_INV_WR: begin
        b_we    = 1'b1;
        b_waddr = cur_word;
        b_wdata = bdata ^ vmask;
      end
      default: ;
    endcase
    if (alc_ok) begin
      fin      = 1'b1;
      f_status = ST_OK;
      f_frame  = alc_f;
      f_kf     = is_reloc && kf_r;
      f_bf     = is_reloc && bf_r;
      f_pte    = is_reloc ? {alc_f, pte_r[PTE_KEEP_W-1:0]} : '0;
    end else if (alc_fail) begin
      fin      = 1'b1;
      f_status = ST_FAIL;
      f_kf     = is_reloc && kf_r;
      f_bf     = is_reloc && bf_r;
      f_pte    = is_reloc ? pte_r : '0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      out_valid_r   <= 1'b0;
      clr_r         <= '0;
      scan_region_r <= '0;
      scan_offset_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin || (out_valid_r && !out_ch.ready);
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (alc_ok) begin
        if (alc_ofs + OFS_W'(1) < OFS_W'(cur_eff)) begin
          scan_region_r <= cur_reg_r;
          scan_offset_r <= PAGES_W'(alc_ofs + OFS_W'(1));
        end else begin
          scan_region_r <= cur_reg_r + REG_W'(1);
          scan_offset_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      o_status_r <= f_status;
      o_frame_r  <= f_frame;
      o_kf_r     <= f_kf;
      o_bf_r     <= f_bf;
      o_pte_r    <= f_pte;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_r     <= in_ch.action;
          frame_r   <= in_ch.frame;
          pte_r     <= in_ch.pte_in;
          probe_r   <= 1'b0;
          cur_reg_r <= (in_ch.action == ACT_ALLOC) ? scan_region_r : '0;
          cur_ofs_r <= (in_ch.action == ACT_ALLOC) ? OFS_W'(scan_offset_r) : '0;
        end
      end
      S_LOOK: begin
        hit_r  <= loc_hit;
        slot_r <= loc_slot;
      end
      S_CHK: begin
        if (probe_r) begin
          cur_ofs_r <= cand_ofs_r + OFS_W'(1);
        end else begin
          kf_r      <= item_kf;
          bf_r      <= item_bf;
          cur_reg_r <= scan_region_r;
          cur_ofs_r <= OFS_W'(scan_offset_r);
        end
      end
      S_ALC_RD, S_INV_RD: begin
        if (!alc_end && alc_skip) begin
          cur_reg_r <= cur_reg_r + REG_W'(1);
          cur_ofs_r <= '0;
        end
      end
      S_ALC_CHK: begin
        if (!pick_any) begin
          cur_ofs_r <= next_ofs;
        end else if (pick_shadow) begin
          cand_ofs_r <= pick_ofs;
          cand_f_r   <= pick_frame;
          probe_r    <= 1'b1;
        end
      end
      S_INV_WR: cur_ofs_r <= next_ofs;
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.frame_out   = o_frame_r;
  assign out_ch.kernel_free = o_kf_r;
  assign out_ch.boot_free   = o_bf_r;
  assign out_ch.pte_out     = o_pte_r;

endmodule
